### src/pac_pkg.sv
// Shared types and constants for the pedometer activity classifier.
// No dependencies; used by pac_ring and pedometer_activity_classifier_top.
package pac_pkg;

    localparam int RING_DEPTH = 8;

    localparam int FORCE_W = 20;
    localparam int TIME_W  = 32;
    localparam int COUNT_W = 32;
    localparam int IN_W    = 72;
    localparam int OUT_W   = 40;
    localparam int CFG_W   = 32;
    localparam int IDX_W   = 2;

    localparam logic [FORCE_W-1:0] STEP_THRESHOLD_RST = 20'd10000;
    localparam logic [TIME_W-1:0]  REST_MIN_RST       = 32'd3000;
    localparam logic [TIME_W-1:0]  RUN_INTERVAL_RST   = 32'd400;

    typedef enum logic [IDX_W-1:0] {
        CFG_STEP_THRESHOLD = 2'd0,
        CFG_REST_MIN       = 2'd1,
        CFG_RUN_INTERVAL   = 2'd2
    } cfg_index_t;

    typedef enum logic [1:0] {
        ACT_RESTING = 2'd0,
        ACT_WALKING = 2'd1,
        ACT_RUNNING = 2'd2
    } activity_t;

    // Ring update request: one new interval per counted step.
    typedef struct packed {
        logic              wr;
        logic [TIME_W-1:0] interval;
    } ring_req_t;

endpackage

### src/pac_ring.sv
// Step interval ring in a synchronous memory plus its running sum.
// Depends on pac_pkg.
module pac_ring #(
    parameter int RING_DEPTH = pac_pkg::RING_DEPTH,
    parameter int SUM_W      = pac_pkg::TIME_W + ((RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 0)
) (
    input  logic                clk,
    input  logic                rst_n,
    input  pac_pkg::ring_req_t  req,
    output logic [SUM_W-1:0]    sum_upd
);

    localparam int PTR_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(RING_DEPTH - 1);

    logic [pac_pkg::TIME_W-1:0] mem [RING_DEPTH];
    logic [pac_pkg::TIME_W-1:0] rdata_reg;
    logic [PTR_W-1:0]           ptr_reg;
    logic [PTR_W-1:0]           ptr_next;
    logic                       full_reg;
    logic                       full_next;
    logic [SUM_W-1:0]           sum_reg;
    logic [SUM_W-1:0]           sum_next;
    logic [SUM_W-1:0]           sum_add;
    logic [pac_pkg::TIME_W-1:0] old_val;

    // Entries are written in pointer order from zero, so every entry is
    // valid once the pointer has wrapped; before that the slot reads zero.
    assign old_val = full_reg ? rdata_reg : '0;

    // Sum after this cycle's request; the held sum when there is none.
    assign sum_upd = sum_next;

    always_comb
    begin
        ptr_next  = ptr_reg;
        full_next = full_reg;
        if (req.wr)
        begin
            ptr_next = (ptr_reg == PTR_LAST) ? '0 : ptr_reg + 1'b1;
            if (ptr_reg == PTR_LAST)
                full_next = 1'b1;
        end
        sum_add  = sum_reg - SUM_W'(old_val) + SUM_W'(req.interval);
        sum_next = req.wr ? sum_add : sum_reg;
    end

    // Read ahead at the next pointer; bypass a write to the same slot.
    always_ff @(posedge clk)
    begin
        if (req.wr)
            mem[ptr_reg] <= req.interval;
        if (req.wr && (ptr_next == ptr_reg))
            rdata_reg <= req.interval;
        else
            rdata_reg <= mem[ptr_next];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg  <= '0;
            full_reg <= 1'b0;
            sum_reg  <= '0;
        end
        else
        begin
            ptr_reg  <= ptr_next;
            full_reg <= full_next;
            sum_reg  <= sum_next;
        end
    end

    a_full_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        full_reg |=> full_reg)
        else $error("ring full flag dropped");

    a_sum_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !req.wr |=> $stable(sum_reg) && $stable(ptr_reg))
        else $error("ring changed without a write");

    a_empty_sum: assert property (@(posedge clk) disable iff (!rst_n)
        (!full_reg && ptr_reg == '0) |-> sum_reg == '0)
        else $error("sum nonzero with empty ring");

endmodule

### src/pedometer_activity_classifier_top.sv
// Pedometer activity classifier top level: step detection, rest timing,
// two-stage pipeline and output register. Depends on pac_pkg and pac_ring.
//
// Usage:
//   s_axis carries one sample per request: right_force, left_force, now_ms.
//   m_axis returns one result per sample: step_total, step_seen, activity
//   and the three LED flags, in sample order.
//   cfg_* writes step_threshold (0), rest_min_ms (1), run_interval_ms (2);
//   other indexes are ignored. cfg_ready is always high. Write only while
//   the pipeline is empty.
// An accepted sample passes the middle stage, then the output register.
// Throughput: one sample per cycle; the ring memory has one write and one
//   read-ahead read per cycle, so consecutive steps never conflict.
// Reset: all state clears at once, registers take their defaults; the ring
//   needs no clearing pass (entries read as zero until first written).
// Stall: with m_tready low the output holds; one more sample is taken into
//   the middle stage, then s_axis_tready drops.
module pedometer_activity_classifier_top #(
    parameter int RING_DEPTH = pac_pkg::RING_DEPTH
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    // [19:0] right_force, [39:20] left_force, [71:40] now_ms
    input  logic [pac_pkg::IN_W-1:0]    s_axis_tdata,
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    // [31:0] step_total, [32] step_seen, [34:33] activity, [35] led_red,
    // [36] led_green, [37] led_yellow, [39:38] zero
    output logic [pac_pkg::OUT_W-1:0]   m_axis_tdata,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [pac_pkg::IDX_W-1:0]   cfg_index,
    input  logic [pac_pkg::CFG_W-1:0]   cfg_data
);

    localparam int SUM_W = pac_pkg::TIME_W + ((RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 0);
    localparam logic [SUM_W-1:0] DEPTH_W = SUM_W'(RING_DEPTH);
    // avg <= run  <=>  sum <= (run + 1) * depth - 1
    localparam logic [SUM_W-1:0] RUN_LIMIT_RST =
        (SUM_W'(pac_pkg::RUN_INTERVAL_RST) + 1'b1) * DEPTH_W - 1'b1;

    typedef struct packed {
        logic [pac_pkg::COUNT_W-1:0] step_total;
        logic                        seen;
        logic                        resting;
        logic [SUM_W-1:0]            sum;
    } s1_t;

    logic [pac_pkg::FORCE_W-1:0] right_force;
    logic [pac_pkg::FORCE_W-1:0] left_force;
    logic [pac_pkg::TIME_W-1:0]  now_ms;

    logic [pac_pkg::FORCE_W-1:0] thr_reg;
    logic [pac_pkg::TIME_W-1:0]  rest_min_reg;
    logic [SUM_W-1:0]            run_limit_reg;

    logic [pac_pkg::COUNT_W-1:0] count_reg;
    logic [pac_pkg::TIME_W-1:0]  last_step_reg;
    logic                        pressed_reg;
    logic                        armed_reg;
    logic [pac_pkg::TIME_W-1:0]  rest_start_reg;

    logic                        s1_valid_reg;
    s1_t                         s1_reg;
    s1_t                         s1_next;
    logic                        out_valid_reg;
    logic [pac_pkg::OUT_W-1:0]   out_reg;
    logic [pac_pkg::OUT_W-1:0]   out_next;
    pac_pkg::activity_t          act_reg;
    pac_pkg::activity_t          act_next;

    logic                        accept;
    logic                        adv;
    logic                        pressed;
    logic                        both;
    logic                        step;
    logic [pac_pkg::TIME_W-1:0]  elapsed;
    logic                        red;
    logic                        green;
    logic                        yellow;
    logic [SUM_W-1:0]            sum_upd;
    pac_pkg::ring_req_t          ring_req;

    assign right_force = s_axis_tdata[19:0];
    assign left_force  = s_axis_tdata[39:20];
    assign now_ms      = s_axis_tdata[71:40];

    assign adv           = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = !s1_valid_reg || adv;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign cfg_ready     = 1'b1;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_reg;

    assign pressed = (right_force <= thr_reg) || (left_force < thr_reg);
    assign both    = (right_force <= thr_reg) && (left_force <= thr_reg);
    assign step    = pressed && !pressed_reg;
    assign elapsed = armed_reg ? now_ms - rest_start_reg : '0;

    assign ring_req.wr       = accept && step;
    assign ring_req.interval = now_ms - last_step_reg;

    pac_ring #(
        .RING_DEPTH (RING_DEPTH),
        .SUM_W      (SUM_W)
    ) u_ring (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (ring_req),
        .sum_upd (sum_upd)
    );

    always_comb
    begin
        s1_next.step_total = count_reg + pac_pkg::COUNT_W'(step);
        s1_next.seen       = step;
        s1_next.resting    = both && (elapsed >= rest_min_reg);
        s1_next.sum        = sum_upd;
    end

    always_comb
    begin
        red      = 1'b0;
        green    = 1'b0;
        yellow   = 1'b0;
        act_next = act_reg;
        if (s1_reg.resting)
        begin
            green    = 1'b1;
            act_next = pac_pkg::ACT_RESTING;
        end
        else if (s1_reg.sum != '0)
        begin
            if (s1_reg.sum <= run_limit_reg)
            begin
                red      = 1'b1;
                act_next = pac_pkg::ACT_RUNNING;
            end
            else
            begin
                yellow   = 1'b1;
                act_next = pac_pkg::ACT_WALKING;
            end
        end
        out_next = {2'b00, yellow, green, red, act_next, s1_reg.seen, s1_reg.step_total};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg       <= pac_pkg::STEP_THRESHOLD_RST;
            rest_min_reg  <= pac_pkg::REST_MIN_RST;
            run_limit_reg <= RUN_LIMIT_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                pac_pkg::CFG_STEP_THRESHOLD: thr_reg <= cfg_data[19:0];
                pac_pkg::CFG_REST_MIN:       rest_min_reg <= cfg_data;
                pac_pkg::CFG_RUN_INTERVAL:
                    run_limit_reg <= (SUM_W'(cfg_data) + 1'b1) * DEPTH_W - 1'b1;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            last_step_reg  <= '0;
            pressed_reg    <= 1'b0;
            armed_reg      <= 1'b0;
            rest_start_reg <= '0;
            s1_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            act_reg        <= pac_pkg::ACT_RESTING;
        end
        else
        begin
            if (accept)
            begin
                pressed_reg <= pressed;
                armed_reg   <= both;
                if (step)
                begin
                    count_reg     <= s1_next.step_total;
                    last_step_reg <= now_ms;
                end
                if (both && !armed_reg)
                    rest_start_reg <= now_ms;
            end
            if (adv)
            begin
                out_valid_reg <= s1_valid_reg;
                if (s1_valid_reg)
                    act_reg <= act_next;
            end
            if (accept)
                s1_valid_reg <= 1'b1;
            else if (adv)
                s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            s1_reg <= s1_next;
        if (adv && s1_valid_reg)
            out_reg <= out_next;
    end

    a_leds_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> $onehot0(out_reg[37:35]))
        else $error("more than one LED lit");

    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !adv) |-> !s_axis_tready)
        else $error("middle stage overwritten while stalled");

    a_step_count: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !step) |=> $stable(count_reg))
        else $error("step count moved without a step");

    a_rest_green: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg[36]) |-> out_reg[34:33] == pac_pkg::ACT_RESTING)
        else $error("green LED without resting state");

endmodule

### test/pedometer_activity_classifier_top_tb.sv
// Stream-level testbench for pedometer_activity_classifier_top: directed and random
// foot-sensor samples are checked against an in-bench model of the step, rest and gait logic.
// Depends on pac_pkg and the RTL under src/.
`timescale 1ns / 1ps

module pedometer_activity_classifier_top_tb;

    localparam int IDLE_LIMIT  = 2000;
    localparam int HOLD_CYCLES = 300;
    localparam int PRINT_LIMIT = 40;
    localparam int PTR_W       = (pac_pkg::RING_DEPTH > 1) ? $clog2(pac_pkg::RING_DEPTH) : 1;
    localparam logic [PTR_W-1:0]            PTR_LAST       = PTR_W'(pac_pkg::RING_DEPTH - 1);
    localparam logic [pac_pkg::FORCE_W-1:0] FORCE_MAX      = '1;
    localparam logic [pac_pkg::IDX_W-1:0]   CFG_IDX_UNUSED = 2'd3;

    typedef struct packed {
        logic [pac_pkg::TIME_W-1:0]  now_ms;
        logic [pac_pkg::FORCE_W-1:0] left_force;
        logic [pac_pkg::FORCE_W-1:0] right_force;
    } sample_t;

    typedef struct packed {
        logic [1:0]                  pad;
        logic                        yellow;
        logic                        green;
        logic                        red;
        pac_pkg::activity_t          act;
        logic                        seen;
        logic [pac_pkg::COUNT_W-1:0] total;
    } result_t;

    typedef enum int {SEG_GAIT, SEG_STAND, SEG_NOISE} seg_kind_t;

    logic                         clk;
    logic                         rst_n         = 1'b0;
    logic                         s_axis_tvalid = 1'b0;
    logic                         s_axis_tready;
    logic [pac_pkg::IN_W-1:0]     s_axis_tdata  = '0;
    logic                         m_axis_tvalid;
    logic                         m_axis_tready = 1'b0;
    logic [pac_pkg::OUT_W-1:0]    m_axis_tdata;
    logic                         cfg_valid     = 1'b0;
    logic                         cfg_ready;
    logic [pac_pkg::IDX_W-1:0]    cfg_index     = '0;
    logic [pac_pkg::CFG_W-1:0]    cfg_data      = '0;

    pedometer_activity_classifier_top u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // model configuration
    logic [pac_pkg::FORCE_W-1:0] thr_m;
    logic [pac_pkg::TIME_W-1:0]  rest_min_m;
    logic [pac_pkg::TIME_W-1:0]  run_m;

    // model state
    logic [pac_pkg::COUNT_W-1:0] step_cnt_m;
    logic [pac_pkg::TIME_W-1:0]  last_step_m;
    logic                        pressed_m;
    logic                        armed_m;
    logic [pac_pkg::TIME_W-1:0]  rest_start_m;
    logic [pac_pkg::TIME_W-1:0]  ring_m [pac_pkg::RING_DEPTH];
    logic [PTR_W-1:0]            ptr_m;
    logic [34:0]                 sum_m;
    pac_pkg::activity_t          act_m;

    sample_t sample_q[$];
    result_t classification_q[$];

    int pushed_cnt    = 0;
    int samples_sent  = 0;
    int results_seen  = 0;
    int mismatch_cnt  = 0;
    int steps_counted = 0;
    int cfg_writes    = 0;
    int n_rest        = 0;
    int n_walk        = 0;
    int n_run         = 0;
    int n_dark        = 0;
    int burst_left    = 0;
    int gap_left      = 0;
    int hold_left     = 0;
    int idle_cycles   = 0;
    logic [7:0] rx_cyc;
    result_t got_r;
    result_t want_r;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    task automatic reset_model();
        thr_m        = pac_pkg::STEP_THRESHOLD_RST;
        rest_min_m   = pac_pkg::REST_MIN_RST;
        run_m        = pac_pkg::RUN_INTERVAL_RST;
        step_cnt_m   = '0;
        last_step_m  = '0;
        pressed_m    = 1'b0;
        armed_m      = 1'b0;
        rest_start_m = '0;
        ring_m       = '{default: '0};
        ptr_m        = '0;
        sum_m        = '0;
        act_m        = pac_pkg::ACT_RESTING;
    endtask

    task automatic classify_sample(input sample_t s);
        logic                       pressed;
        logic                       both;
        logic                       seen;
        logic                       resting;
        logic [pac_pkg::TIME_W-1:0] interval;
        logic [pac_pkg::TIME_W-1:0] elapsed;
        logic [34:0]                avg;
        result_t                    r;
        pressed = (s.right_force <= thr_m) || (s.left_force < thr_m);
        both    = (s.right_force <= thr_m) && (s.left_force <= thr_m);
        seen    = 1'b0;
        resting = 1'b0;
        if (pressed && !pressed_m)
        begin
            interval      = s.now_ms - last_step_m;
            seen          = 1'b1;
            step_cnt_m    = step_cnt_m + 1'b1;
            sum_m         = sum_m - {3'b000, ring_m[ptr_m]} + {3'b000, interval};
            ring_m[ptr_m] = interval;
            ptr_m         = (ptr_m == PTR_LAST) ? '0 : ptr_m + 1'b1;
            last_step_m   = s.now_ms;
        end
        pressed_m = pressed;
        if (both)
        begin
            if (!armed_m)
            begin
                armed_m      = 1'b1;
                rest_start_m = s.now_ms;
            end
            elapsed = s.now_ms - rest_start_m;
            resting = (elapsed >= rest_min_m);
        end
        else
            armed_m = 1'b0;
        r = '0;
        if (resting)
        begin
            act_m   = pac_pkg::ACT_RESTING;
            r.green = 1'b1;
        end
        else if (sum_m != '0)
        begin
            avg = sum_m / 35'(pac_pkg::RING_DEPTH);
            if (avg <= {3'b000, run_m})
            begin
                act_m = pac_pkg::ACT_RUNNING;
                r.red = 1'b1;
            end
            else
            begin
                act_m    = pac_pkg::ACT_WALKING;
                r.yellow = 1'b1;
            end
        end
        r.total = step_cnt_m;
        r.seen  = seen;
        r.act   = act_m;
        classification_q.push_back(r);
        if (seen)
            steps_counted++;
    endtask

    task automatic report_mismatch(input string field, input logic [pac_pkg::OUT_W-1:0] got,
                                   input logic [pac_pkg::OUT_W-1:0] want);
        mismatch_cnt++;
        if (mismatch_cnt <= PRINT_LIMIT)
            $display("mismatch %s at result %0d: got %h expected %h",
                     field, results_seen, got, want);
    endtask

    task automatic push_sample(input logic [pac_pkg::FORCE_W-1:0] r,
                               input logic [pac_pkg::FORCE_W-1:0] l,
                               input logic [pac_pkg::TIME_W-1:0] t);
        sample_q.push_back('{now_ms: t, left_force: l, right_force: r});
        pushed_cnt++;
    endtask

    function automatic logic [pac_pkg::FORCE_W-1:0] right_press();
        if ($urandom_range(0, 7) == 0)
            return thr_m;
        return pac_pkg::FORCE_W'($urandom_range(0, thr_m));
    endfunction

    function automatic logic [pac_pkg::FORCE_W-1:0] left_press();
        if (thr_m == '0)
            return '0;
        if ($urandom_range(0, 7) == 0)
            return thr_m - 1'b1;
        return pac_pkg::FORCE_W'($urandom_range(0, thr_m - 1'b1));
    endfunction

    function automatic logic [pac_pkg::FORCE_W-1:0] release_force();
        if (thr_m == FORCE_MAX)
            return FORCE_MAX;
        if ($urandom_range(0, 7) == 0)
            return thr_m + 1'b1;
        return pac_pkg::FORCE_W'($urandom_range(thr_m + 1'b1, FORCE_MAX));
    endfunction

    // gait, standing and noise segments built around the current threshold
    task automatic gen_random(input int n);
        seg_kind_t                   kind;
        int                          seg_left;
        int                          period;
        int                          sel;
        logic                        on;
        logic [pac_pkg::TIME_W-1:0]  t;
        logic [pac_pkg::TIME_W-1:0]  span;
        logic [pac_pkg::TIME_W-1:0]  raw;
        logic [pac_pkg::FORCE_W-1:0] r;
        logic [pac_pkg::FORCE_W-1:0] l;
        kind     = SEG_GAIT;
        seg_left = 0;
        period   = 100;
        on       = 1'b0;
        t        = $urandom;
        span     = (rest_min_m > 32'd60000) ? '1 : rest_min_m / 3 + 4;
        for (int k = 0; k < n; k++)
        begin
            if (seg_left == 0)
            begin
                sel      = $urandom_range(0, 99);
                kind     = (sel < 60) ? SEG_GAIT : (sel < 85) ? SEG_STAND : SEG_NOISE;
                seg_left = $urandom_range(4, 24);
                period   = $urandom_range(20, 1200);
            end
            seg_left--;
            case (kind)
                SEG_GAIT:
                begin
                    on = !on;
                    sel = $urandom_range(0, 2);
                    if (!on)
                    begin
                        r = release_force();
                        l = ($urandom_range(0, 5) == 0) ? thr_m : release_force();
                    end
                    else if (sel == 0)
                    begin
                        r = right_press();
                        l = release_force();
                    end
                    else if (sel == 1)
                    begin
                        r = release_force();
                        l = left_press();
                    end
                    else
                    begin
                        r = right_press();
                        l = left_press();
                    end
                    t = t + $urandom_range(1, period);
                end
                SEG_STAND:
                begin
                    r = right_press();
                    l = pac_pkg::FORCE_W'($urandom_range(0, thr_m));
                    t = t + ((span == '1) ? $urandom : $urandom_range(0, span));
                end
                default:
                begin
                    raw = $urandom;
                    r   = raw[pac_pkg::FORCE_W-1:0];
                    raw = $urandom;
                    l   = raw[pac_pkg::FORCE_W-1:0];
                    t   = $urandom;
                end
            endcase
            push_sample(r, l, t);
        end
    endtask

    task automatic wait_idle();
        while (samples_sent != pushed_cnt || classification_q.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    // leaves cfg_valid high so back-to-back writes need one assignment per edge
    task automatic write_reg(input logic [pac_pkg::IDX_W-1:0] idx,
                             input logic [pac_pkg::CFG_W-1:0] val);
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_writes++;
        if (idx == pac_pkg::CFG_STEP_THRESHOLD)
            thr_m = val[pac_pkg::FORCE_W-1:0];
        else if (idx == pac_pkg::CFG_REST_MIN)
            rest_min_m = val;
        else if (idx == pac_pkg::CFG_RUN_INTERVAL)
            run_m = val;
    endtask

    task automatic set_config(input logic [pac_pkg::FORCE_W-1:0] thr,
                              input logic [pac_pkg::TIME_W-1:0] rest,
                              input logic [pac_pkg::TIME_W-1:0] run);
        write_reg(pac_pkg::CFG_STEP_THRESHOLD, {12'd0, thr});
        write_reg(pac_pkg::CFG_REST_MIN, rest);
        write_reg(pac_pkg::CFG_RUN_INTERVAL, run);
        write_reg(CFG_IDX_UNUSED, $urandom);
        cfg_valid <= 1'b0;
    endtask

    // sender: bursts and gaps, holds the request until taken
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            burst_left = 0;
            gap_left   = 0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                classify_sample(sample_t'(s_axis_tdata));
                samples_sent++;
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (gap_left != 0)
                begin
                    gap_left--;
                    s_axis_tvalid <= 1'b0;
                end
                else if (sample_q.size() != 0)
                begin
                    s_axis_tdata  <= sample_q.pop_front();
                    s_axis_tvalid <= 1'b1;
                    if (burst_left <= 1)
                    begin
                        burst_left = $urandom_range(1, 40);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                    end
                    else
                        burst_left--;
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // receiver: checks results, stalls on its own pattern plus two long hold-offs
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            rx_cyc    = '0;
            hold_left = 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got_r = result_t'(m_axis_tdata);
                if (classification_q.size() == 0)
                    report_mismatch("result with no sample", got_r, '0);
                else
                begin
                    want_r = classification_q.pop_front();
                    if (got_r.total !== want_r.total)
                        report_mismatch("step_total", got_r, want_r);
                    if (got_r.seen !== want_r.seen)
                        report_mismatch("step_seen", got_r, want_r);
                    if (got_r.act !== want_r.act)
                        report_mismatch("activity", got_r, want_r);
                    if (got_r.red !== want_r.red)
                        report_mismatch("led_red", got_r, want_r);
                    if (got_r.green !== want_r.green)
                        report_mismatch("led_green", got_r, want_r);
                    if (got_r.yellow !== want_r.yellow)
                        report_mismatch("led_yellow", got_r, want_r);
                    if (got_r.pad !== want_r.pad)
                        report_mismatch("padding", got_r, want_r);
                    if (want_r.green)
                        n_rest++;
                    else if (want_r.yellow)
                        n_walk++;
                    else if (want_r.red)
                        n_run++;
                    else
                        n_dark++;
                end
                results_seen++;
                if (results_seen == 450 || results_seen == 1000)
                    hold_left = HOLD_CYCLES;
            end
            rx_cyc++;
            if (hold_left != 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                case (rx_cyc[7:6])
                    2'd0:    m_axis_tready <= 1'b1;
                    2'd1:    m_axis_tready <= ($urandom_range(0, 1) == 0);
                    2'd2:    m_axis_tready <= ($urandom_range(0, 7) == 0);
                    default: m_axis_tready <= (rx_cyc[2:0] != 3'd0);
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
                (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("[pedometer_activity_classifier_top] ERROR");
                $finish;
            end
        end
    end

    initial
    begin
        reset_model();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset defaults: edges, threshold boundaries, rest timing, timestamp wrap
        push_sample(FORCE_MAX, FORCE_MAX, 32'd0);
        push_sample(20'd0, FORCE_MAX, 32'd100);
        push_sample(FORCE_MAX, FORCE_MAX, 32'd200);
        push_sample(FORCE_MAX, 20'd10000, 32'd300);
        push_sample(FORCE_MAX, 20'd9999, 32'd400);
        push_sample(FORCE_MAX, FORCE_MAX, 32'd500);
        push_sample(20'd10000, FORCE_MAX, 32'd600);
        push_sample(20'd10000, 20'd10000, 32'd700);
        push_sample(20'd0, 20'd0, 32'd3699);
        push_sample(20'd5, 20'd7, 32'd3700);
        push_sample(FORCE_MAX, FORCE_MAX, 32'd3800);
        push_sample(20'd0, FORCE_MAX, 32'hFFFF_F000);
        push_sample(FORCE_MAX, FORCE_MAX, 32'hFFFF_FFF0);
        push_sample(FORCE_MAX, 20'd0, 32'hFFFF_FFFF);
        push_sample(FORCE_MAX, FORCE_MAX, 32'd0);
        push_sample(20'd0, FORCE_MAX, 32'd20);
        for (int i = 0; i < 6; i++)
        begin
            push_sample(FORCE_MAX, FORCE_MAX, 32'd80 + i * 120);
            push_sample(20'd0, FORCE_MAX, 32'd140 + i * 120);
        end
        wait_idle();

        // zero threshold, zero rest time, zero run interval
        set_config('0, '0, '0);
        push_sample(20'd0, FORCE_MAX, 32'd1000);
        push_sample(20'd1, 20'd0, 32'd1001);
        push_sample(20'd0, 20'd0, 32'd1002);
        push_sample(FORCE_MAX, FORCE_MAX, 32'd1003);
        push_sample(20'd0, FORCE_MAX, 32'd1004);
        push_sample(FORCE_MAX, FORCE_MAX, 32'd9000);
        push_sample(20'd0, FORCE_MAX, 32'd9001);
        wait_idle();

        // all-ones settings: everything presses, rest needs a full wrap
        set_config(FORCE_MAX, '1, '1);
        push_sample(FORCE_MAX, FORCE_MAX, 32'd10);
        push_sample(FORCE_MAX, FORCE_MAX, 32'd9);
        push_sample(FORCE_MAX, FORCE_MAX, 32'd8);
        wait_idle();

        set_config(pac_pkg::FORCE_W'($urandom_range(2000, 60000)), $urandom_range(0, 4000),
                   $urandom_range(100, 900));
        gen_random(300);
        wait_idle();

        set_config(pac_pkg::FORCE_W'($urandom), $urandom_range(0, 2000),
                   $urandom_range(0, 1500));
        gen_random(300);
        wait_idle();

        set_config(pac_pkg::FORCE_W'($urandom_range(1, 20'hFFFFE)), $urandom, $urandom);
        gen_random(300);
        wait_idle();

        set_config(pac_pkg::FORCE_W'($urandom_range(100, 20000)), $urandom_range(200, 6000),
                   $urandom_range(200, 800));
        gen_random(300);
        wait_idle();

        repeat (4) @(posedge clk);
        $display("covered %0d samples, %0d steps, %0d register writes, %0d mismatches",
                 samples_sent, steps_counted, cfg_writes, mismatch_cnt);
        $display("states seen: %0d resting, %0d walking, %0d running, %0d with LEDs off",
                 n_rest, n_walk, n_run, n_dark);
        if (mismatch_cnt == 0 && classification_q.size() == 0)
            $display("[pedometer_activity_classifier_top] OK");
        else
            $display("[pedometer_activity_classifier_top] ERROR");
        $finish;
    end

endmodule
